FILE: rtl/rmwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwd_pkg
// Shared types, constants and elaboration-time tables for the ray march block.
// ----------------------------------------------------------------------------
package rmwd_pkg;

	localparam int ANGLE_BITS = 12;
	localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
	localparam int QIDX_W     = ANGLE_BITS - 1;
	localparam int FRAC_BITS  = 14;
	localparam int SINE_MAG_W = FRAC_BITS + 1;
	localparam int SINE_W     = FRAC_BITS + 2;

	localparam int POS_W        = 18;
	localparam int PRE_SHIFT    = 6;
	localparam int QUO_W        = 10;
	localparam int RECIP_SH     = 34;
	localparam int SPLIT_CYCLES = 3;
	localparam int CNT_W        = 2;
	localparam int CELL_W       = QUO_W + 1;
	localparam int COORD_W      = 6;
	localparam int MAP_IDX_W    = 2 * COORD_W;

	localparam int                 DIST_W   = 10;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam int LAYOUT_COLS  = 11;
	localparam int LAYOUT_ROWS  = 9;
	localparam int LAYOUT_CELLS = LAYOUT_COLS * LAYOUT_ROWS;
	localparam int LAYOUT_IDX_W = 7;

	localparam longint unsigned Q30_ONE     = 64'd1 << 30;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MARCH,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic div;
		logic div_last;
		logic step;
		logic load_d;
	} axis_cmd_t;

	typedef struct packed {
		logic outside;
		logic wall;
	} probe_t;

	typedef logic [SINE_MAG_W-1:0] sine_tbl_t [0:QUARTER];

	// outer ring of walls plus one wall cell at row 1, column 5
	function automatic logic [LAYOUT_CELLS-1:0] build_layout();
		logic [LAYOUT_CELLS-1:0] v;
		int r;
		int c;
		v = '0;
		for (int i = 0; i < LAYOUT_CELLS; i++) begin
			r = i / LAYOUT_COLS;
			c = i % LAYOUT_COLS;
			v[i] = (r == 0) || (r == LAYOUT_ROWS - 1) || (c == 0) ||
				(c == LAYOUT_COLS - 1) || ((r == 1) && (c == 5));
		end
		return v;
	endfunction

	localparam logic [LAYOUT_CELLS-1:0] LAYOUT = build_layout();

	// odd polynomial quarter wave in q30, rounded to q14 and clamped
	function automatic logic [SINE_MAG_W-1:0] quarter_sine(int unsigned r);
		longint unsigned u;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned a;
		longint unsigned s;
		longint unsigned v;
		u  = longint'(r) << (32 - ANGLE_BITS);
		x  = (u * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		a  = Q30_ONE - x2 / 72;
		a  = Q30_ONE - ((x2 * a) >> 30) / 42;
		a  = Q30_ONE - ((x2 * a) >> 30) / 20;
		a  = Q30_ONE - ((x2 * a) >> 30) / 6;
		s  = (x * a) >> 30;
		v  = (s + (64'd1 << 15)) >> 16;
		if (v > (64'd1 << FRAC_BITS)) begin
			v = 64'd1 << FRAC_BITS;
		end
		return v[SINE_MAG_W-1:0];
	endfunction

	function automatic sine_tbl_t build_sine_tbl();
		sine_tbl_t t;
		for (int i = 0; i <= QUARTER; i++) begin
			t[i] = quarter_sine(i);
		end
		return t;
	endfunction

endpackage

FILE: rtl/rmwd_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwd_sine_rom
// Quarter-wave sine rom with registered read; folds the angle into the first
// quadrant and restores the sign after the read.
// ----------------------------------------------------------------------------
module rmwd_sine_rom (
	input  logic                                 clk,
	input  logic [rmwd_pkg::ANGLE_BITS-1:0]      angle,
	output logic signed [rmwd_pkg::SINE_W-1:0]   value
);

	localparam rmwd_pkg::sine_tbl_t SINE_TBL = rmwd_pkg::build_sine_tbl();

	logic [1:0]                        quad;
	logic [rmwd_pkg::ANGLE_BITS-3:0]   frac;
	logic [rmwd_pkg::QIDX_W-1:0]       addr;
	logic [rmwd_pkg::SINE_MAG_W-1:0]   mag_q;
	logic                              neg_q;
	logic signed [rmwd_pkg::SINE_W-1:0] mag_s;

	assign quad = angle[rmwd_pkg::ANGLE_BITS-1 -: 2];
	assign frac = angle[rmwd_pkg::ANGLE_BITS-3:0];

	// odd quadrants run the quarter wave backwards
	always_comb begin
		if (quad[0]) begin
			addr = rmwd_pkg::QIDX_W'(rmwd_pkg::QUARTER) - {1'b0, frac};
		end else begin
			addr = {1'b0, frac};
		end
	end

	always_ff @(posedge clk) begin
		mag_q <= SINE_TBL[addr];
		neg_q <= quad[1];
	end

	assign mag_s = $signed({1'b0, mag_q});
	assign value = neg_q ? -mag_s : mag_s;

endmodule

FILE: rtl/rmwd_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwd_axis
// One coordinate lane: splits the start position into cell and remainder with
// a reciprocal multiply and a multiply-subtract, then advances the remainder
// by the direction term each march step, carrying into the cell.
// ----------------------------------------------------------------------------
module rmwd_axis #(
	parameter int CELL_SIZE = 70
) (
	input  logic                                 clk,
	input  rmwd_pkg::axis_cmd_t                  cmd,
	input  logic [rmwd_pkg::POS_W-1:0]           start,
	input  logic signed [rmwd_pkg::SINE_W-1:0]   rom_val,
	output logic signed [rmwd_pkg::CELL_W-1:0]   cell_idx
);

	localparam int EXT    = CELL_SIZE << rmwd_pkg::FRAC_BITS;
	localparam int DIVR   = CELL_SIZE << (rmwd_pkg::FRAC_BITS - rmwd_pkg::PRE_SHIFT);
	localparam int RW     = $clog2(EXT);
	localparam int SW     = RW + 2;
	localparam int PROD_W = rmwd_pkg::RECIP_SH + rmwd_pkg::QUO_W;
	localparam int BACK_W = rmwd_pkg::POS_W + rmwd_pkg::QUO_W;

	localparam longint RECIP =
		((longint'(1) << rmwd_pkg::RECIP_SH) + longint'(DIVR) - 1) / longint'(DIVR);

	localparam logic [PROD_W-1:0]          RECIP_P = PROD_W'(RECIP);
	localparam logic [rmwd_pkg::POS_W-1:0] DIVR_P  = rmwd_pkg::POS_W'(DIVR);
	localparam logic signed [SW-1:0]       EXT_S   = SW'(EXT);

	logic [rmwd_pkg::POS_W-1:0]             pos_q;
	logic [rmwd_pkg::QUO_W-1:0]             quo_q;
	logic [RW-1:0]                          rem_q;
	logic signed [rmwd_pkg::CELL_W-1:0]     cell_q;
	logic signed [rmwd_pkg::SINE_W-1:0]     d_q;

	logic [PROD_W-1:0]          quo_prod;
	logic [BACK_W-1:0]          back_prod;
	logic [rmwd_pkg::POS_W-1:0] slip;
	logic signed [SW-1:0]       t;
	logic signed [SW-1:0]       t_lo;
	logic signed [SW-1:0]       t_hi;

	// cell by reciprocal multiply, remainder by multiply-subtract
	assign quo_prod  = PROD_W'(pos_q) * RECIP_P;
	assign back_prod = BACK_W'(quo_q) * BACK_W'(DIVR_P);
	assign slip      = pos_q - back_prod[rmwd_pkg::POS_W-1:0];

	// march step
	assign t    = $signed({2'b00, rem_q}) + SW'(d_q);
	assign t_lo = t + EXT_S;
	assign t_hi = t - EXT_S;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q  <= start;
			cell_q <= '0;
		end else if (cmd.div) begin
			if (cmd.div_last) begin
				rem_q  <= RW'({slip, {rmwd_pkg::PRE_SHIFT{1'b0}}});
				cell_q <= {1'b0, quo_q};
			end else begin
				quo_q <= quo_prod[rmwd_pkg::RECIP_SH +: rmwd_pkg::QUO_W];
			end
		end else if (cmd.step) begin
			if (t < 0) begin
				rem_q  <= t_lo[RW-1:0];
				cell_q <= cell_q - rmwd_pkg::CELL_W'(1);
			end else if (t >= EXT_S) begin
				rem_q  <= t_hi[RW-1:0];
				cell_q <= cell_q + rmwd_pkg::CELL_W'(1);
			end else begin
				rem_q <= t[RW-1:0];
			end
		end
		if (cmd.load_d) begin
			d_q <= rom_val;
		end
	end

	assign cell_idx = cell_q;

endmodule

FILE: rtl/rmwd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmwd_ctrl
// Sequencer: takes an input beat, runs the start division while fetching
// cosine and sine, then steps the lanes until the probe or the distance limit stops the march.
// ----------------------------------------------------------------------------
module rmwd_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [rmwd_pkg::ANGLE_BITS-1:0]     heading,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rmwd_pkg::DIST_W-1:0]         wall_distance,
	output logic                                left_map,
	input  rmwd_pkg::probe_t                    probe,
	output rmwd_pkg::axis_cmd_t                 cmd_x,
	output rmwd_pkg::axis_cmd_t                 cmd_y,
	output logic [rmwd_pkg::ANGLE_BITS-1:0]     rom_angle
);

	rmwd_pkg::ctrl_state_t state_q, state_nxt;

	logic [rmwd_pkg::CNT_W-1:0]      cnt_q;
	logic [rmwd_pkg::DIST_W-1:0]     dist_q;
	logic [rmwd_pkg::ANGLE_BITS-1:0] angle_q;
	logic                            left_q;
	logic                            accept;
	logic                            div_last;
	logic                            stop;

	assign accept   = in_valid && in_ready;
	assign div_last = (cnt_q == rmwd_pkg::CNT_W'(rmwd_pkg::SPLIT_CYCLES - 1));
	assign stop     = probe.outside || probe.wall || (dist_q == rmwd_pkg::DIST_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmwd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd_x     = '0;
		cmd_y     = '0;
		rom_angle = angle_q;
		case (state_q)
			rmwd_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd_x.load = in_valid;
				cmd_y.load = in_valid;
				if (in_valid) begin
					state_nxt = rmwd_pkg::ST_DIV;
				end
			end
			rmwd_pkg::ST_DIV: begin
				cmd_x.div      = 1'b1;
				cmd_y.div      = 1'b1;
				cmd_x.div_last = div_last;
				cmd_y.div_last = div_last;
				// cosine read first, sine in the next cycle
				if (cnt_q == '0) begin
					rom_angle = angle_q + rmwd_pkg::ANGLE_BITS'(rmwd_pkg::QUARTER);
				end
				cmd_x.load_d = (cnt_q == rmwd_pkg::CNT_W'(1));
				cmd_y.load_d = (cnt_q == rmwd_pkg::CNT_W'(2));
				if (div_last) begin
					state_nxt = rmwd_pkg::ST_MARCH;
				end
			end
			rmwd_pkg::ST_MARCH: begin
				cmd_x.step = !stop;
				cmd_y.step = !stop;
				if (stop) begin
					state_nxt = rmwd_pkg::ST_OUT;
				end
			end
			rmwd_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_nxt = rmwd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = rmwd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			dist_q <= '0;
			left_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q  <= '0;
				dist_q <= '0;
			end else if (state_q == rmwd_pkg::ST_DIV) begin
				cnt_q <= cnt_q + rmwd_pkg::CNT_W'(1);
			end else if (state_q == rmwd_pkg::ST_MARCH) begin
				if (stop) begin
					left_q <= probe.outside;
				end else begin
					dist_q <= dist_q + rmwd_pkg::DIST_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			angle_q <= heading;
		end
	end

	assign wall_distance = dist_q;
	assign left_map      = left_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and result beats offered together");

	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == rmwd_pkg::ST_DIV) && (cnt_q == '0) && (dist_q == '0))
		else $error("input beat did not start the division");

	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmwd_pkg::ST_MARCH && dist_q == rmwd_pkg::DIST_MAX)
		|=> (state_q == rmwd_pkg::ST_OUT) && (wall_distance == rmwd_pkg::DIST_MAX))
		else $error("march ran past the distance limit");

	a_out_from_march: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == rmwd_pkg::ST_MARCH)
		else $error("result raised without a march");

	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready)
		else $error("block not ready after result beat");

endmodule

FILE: rtl/ray_march_wall_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_march_wall_distance
// Marches a ray from a start position in unit steps over a fixed wall map and
// returns the step count and whether the ray left the map.
// ----------------------------------------------------------------------------
// wall_distance is the number of march steps taken (0..1023)
// a new input beat is accepted only in idle, after the result beat has been taken
// the march unit does one step per cycle; the start split runs while cosine and sine are read
// reset clears the sequencer only; the wall map is a fixed constant
module ray_march_wall_distance #(
	parameter int MAP_COLS  = 11,
	parameter int MAP_ROWS  = 9,
	parameter int CELL_SIZE = 70
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rmwd_pkg::POS_W-1:0]         start_x,
	input  logic [rmwd_pkg::POS_W-1:0]         start_y,
	input  logic [rmwd_pkg::ANGLE_BITS-1:0]    heading,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rmwd_pkg::DIST_W-1:0]        wall_distance,
	output logic                               left_map
);

	rmwd_pkg::axis_cmd_t                 cmd_x;
	rmwd_pkg::axis_cmd_t                 cmd_y;
	rmwd_pkg::probe_t                    probe;
	logic [rmwd_pkg::ANGLE_BITS-1:0]     rom_angle;
	logic signed [rmwd_pkg::SINE_W-1:0]  rom_val;
	logic signed [rmwd_pkg::CELL_W-1:0]  cell_x;
	logic signed [rmwd_pkg::CELL_W-1:0]  cell_y;
	logic [rmwd_pkg::MAP_IDX_W-1:0]      map_idx;
	logic                                out_x;
	logic                                out_y;

	rmwd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.heading       (heading),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.wall_distance (wall_distance),
		.left_map      (left_map),
		.probe         (probe),
		.cmd_x         (cmd_x),
		.cmd_y         (cmd_y),
		.rom_angle     (rom_angle)
	);

	rmwd_sine_rom u_rom (
		.clk   (clk),
		.angle (rom_angle),
		.value (rom_val)
	);

	rmwd_axis #(
		.CELL_SIZE (CELL_SIZE)
	) u_axis_x (
		.clk      (clk),
		.cmd      (cmd_x),
		.start    (start_x),
		.rom_val  (rom_val),
		.cell_idx (cell_x)
	);

	rmwd_axis #(
		.CELL_SIZE (CELL_SIZE)
	) u_axis_y (
		.clk      (clk),
		.cmd      (cmd_y),
		.start    (start_y),
		.rom_val  (rom_val),
		.cell_idx (cell_y)
	);

	// cell lookup against the map bounds and the wall layout
	assign out_x = cell_x[rmwd_pkg::CELL_W-1] ||
		(cell_x[rmwd_pkg::CELL_W-2:0] >= (rmwd_pkg::CELL_W - 1)'(MAP_COLS));
	assign out_y = cell_y[rmwd_pkg::CELL_W-1] ||
		(cell_y[rmwd_pkg::CELL_W-2:0] >= (rmwd_pkg::CELL_W - 1)'(MAP_ROWS));

	assign map_idx = rmwd_pkg::MAP_IDX_W'(cell_y[rmwd_pkg::COORD_W-1:0]) *
		rmwd_pkg::MAP_IDX_W'(MAP_COLS) +
		rmwd_pkg::MAP_IDX_W'(cell_x[rmwd_pkg::COORD_W-1:0]);

	assign probe.outside = out_x || out_y;
	assign probe.wall    = (map_idx < rmwd_pkg::MAP_IDX_W'(rmwd_pkg::LAYOUT_CELLS)) &&
		rmwd_pkg::LAYOUT[map_idx[rmwd_pkg::LAYOUT_IDX_W-1:0]];

endmodule
